[rtl/core/sparse_matrix_entry_table_defines.svh]
// Assertion macros shared by the sparse matrix entry table RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SPARSE_MATRIX_ENTRY_TABLE_DEFINES_SVH
`define SPARSE_MATRIX_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMET_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sparse matrix entry table: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SMET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse matrix entry table: next-cycle check failed");

`endif

[rtl/core/smet_pkg.sv]
// Shared types and constants for the sparse matrix entry table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smet_pkg;

  localparam int ENTRIES    = 64;
  localparam int INDEX_BITS = 16;
  localparam int COORD_W    = 16;
  localparam int DATA_W     = 32;
  localparam int KEY_W      = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;
  localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Input tdata layout, lowest bit up: row, column, value
  localparam int ROW_LSB = 0;
  localparam int COL_LSB = COORD_W;
  localparam int VAL_LSB = 2 * COORD_W;
  localparam int S_TDATA_W = 2 * COORD_W + DATA_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [KEY_W-1:0]  row;
    logic [KEY_W-1:0]  col;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Write request into the entry store
  typedef struct packed {
    logic              mem_en;
    logic              vld_en;
    logic              vld_val;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } smet_wr_t;

  // Scan outcome from the match unit
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [DATA_W-1:0] hit_data;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } smet_match_t;

endpackage

[rtl/core/smet_store.sv]
// Entry store: key/value memory with one registered read port and valid flops.
// Depends on smet_pkg.
`timescale 1ns / 1ps

module smet_store
  import smet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  input  smet_wr_t          wr_i,
  output logic              rd_vld_o,
  output logic [SLOT_W-1:0] rd_idx_o,
  output entry_t            rd_entry_o,
  output logic              rd_valid_o
);

  entry_t            mem_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  entry_t            rd_entry_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_valid_q;
  logic              rd_vld_q;

  // Write and read the key/value memory
  always_ff @(posedge clk_i) begin
    if (wr_i.mem_en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
      rd_idx_q   <= rd_addr_i;
    end
  end

  // Hold valid marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (wr_i.vld_en) begin
        valid_q[wr_i.addr] <= wr_i.vld_val;
      end
      rd_vld_q <= rd_en_i;
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_vld_o   = rd_vld_q;
  assign rd_idx_o   = rd_idx_q;
  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

[rtl/core/smet_match.sv]
// Shared compare unit: checks one stored entry per cycle against the key while cmp_vld_i is set.
// Tracks the first matching slot and the first free slot. Depends on smet_pkg.
`timescale 1ns / 1ps

module smet_match
  import smet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cmp_vld_i,
  input  logic [SLOT_W-1:0] idx_i,
  input  entry_t            entry_i,
  input  logic              valid_i,
  input  logic [KEY_W-1:0]  key_row_i,
  input  logic [KEY_W-1:0]  key_col_i,
  output smet_match_t       status_o
);

  logic              hit_q;
  logic              free_q;
  logic [SLOT_W-1:0] hit_idx_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [DATA_W-1:0] hit_data_q;
  logic              take_hit;
  logic              take_free;

  // Compare the entry under test
  assign take_hit  = cmp_vld_i && valid_i && !hit_q &&
                     (entry_i.row == key_row_i) && (entry_i.col == key_col_i);
  assign take_free = cmp_vld_i && !valid_i && !free_q;

  // Track found flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (start_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (take_hit) begin
        hit_q <= 1'b1;
      end
      if (take_free) begin
        free_q <= 1'b1;
      end
    end
  end

  // Capture slot numbers and the matching value
  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q  <= idx_i;
      hit_data_q <= entry_i.data;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
  end

  assign status_o.hit      = hit_q;
  assign status_o.hit_idx  = hit_idx_q;
  assign status_o.hit_data = hit_data_q;
  assign status_o.free     = free_q;
  assign status_o.free_idx = free_idx_q;

endmodule

[rtl/core/sparse_matrix_entry_table.sv]
// Top level of the sparse matrix entry table: command sequencer and result register.
// Depends on smet_pkg, smet_store, smet_match and the assertion macro header.
`timescale 1ns / 1ps
`include "sparse_matrix_entry_table_defines.svh"

// Keeps up to ENTRIES cells of a sparse 2-D array as (row, column) -> value entries.
// Each input item is one command (set, get, delete) and yields exactly one result
// item. A command is accepted in ST_IDLE; in ST_SCAN the single read port of the
// entry memory walks the whole table, ST_DRAIN does the last compare and ST_FINISH
// updates the table and loads the result. The result register lets the next item
// be accepted while a result waits; a command that finishes before the previous
// result is taken holds until it is. Valid marks are flops cleared by reset, so the
// table is usable right after reset. A set with no match and no free slot is dropped
// and flagged in status. The value returned for absent cells is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while no command is in flight,
// as the block itself does not enforce this.
module sparse_matrix_entry_table
  import smet_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: value returned for absent cells
  input  logic                 cfg_we_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i,
  // command items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: row_index[15:0], col_index[31:16], write_value[63:32]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]           s_axis_tuser,
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: read_value[31:0]
  output logic [DATA_W-1:0]    m_axis_tdata,
  // tuser: found[0], status[1]
  output logic [1:0]           m_axis_tuser
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic [1:0]        cmd_q;
  logic [KEY_W-1:0]  key_row_q;
  logic [KEY_W-1:0]  key_col_q;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] default_q;
  logic              out_vld_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_found_q;
  logic              out_status_q;

  logic              accept;
  logic              out_load;
  logic              rd_en;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  entry_t            rd_entry;
  logic              rd_valid;
  smet_match_t       match;
  smet_wr_t          wr;
  logic [DATA_W-1:0] res_data;
  logic              res_found;
  logic              res_status;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_en         = (state_q == ST_SCAN);
  assign out_load      = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  smet_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q),
    .wr_i       (wr),
    .rd_vld_o   (rd_vld),
    .rd_idx_o   (rd_idx),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  smet_match u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .cmp_vld_i (rd_vld),
    .idx_i     (rd_idx),
    .entry_i   (rd_entry),
    .valid_i   (rd_valid),
    .key_row_i (key_row_q),
    .key_col_i (key_col_q),
    .status_o  (match)
  );

  // Sequence the scan
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == LAST_SLOT) begin
          state_d = ST_DRAIN;
          scan_d  = '0;
        end else begin
          scan_d = scan_q + SLOT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        scan_d  = '0;
      end
    endcase
  end

  // Form the table update and the result
  always_comb begin
    wr.mem_en      = 1'b0;
    wr.vld_en      = 1'b0;
    wr.vld_val     = 1'b0;
    wr.addr        = match.hit_idx;
    wr.entry.row   = key_row_q;
    wr.entry.col   = key_col_q;
    wr.entry.data  = value_q;
    res_data       = '0;
    res_found      = 1'b0;
    res_status     = 1'b0;
    case (cmd_q)
      CMD_SET: begin
        if (match.hit) begin
          wr.mem_en = out_load;
          res_found = 1'b1;
        end else if (match.free) begin
          wr.addr    = match.free_idx;
          wr.mem_en  = out_load;
          wr.vld_en  = out_load;
          wr.vld_val = 1'b1;
        end else begin
          res_status = 1'b1;
        end
      end
      CMD_GET: begin
        res_found = match.hit;
        res_data  = match.hit ? match.hit_data : default_q;
      end
      CMD_DEL: begin
        if (match.hit) begin
          wr.vld_en = out_load;
          res_found = 1'b1;
        end
      end
      default: begin
        res_data = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      out_vld_q <= 1'b0;
      default_q <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        default_q <= cfg_wdata_i;
      end
    end
  end

  // Latch the command item and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= s_axis_tuser;
      key_row_q <= s_axis_tdata[ROW_LSB +: KEY_W];
      key_col_q <= s_axis_tdata[COL_LSB +: KEY_W];
      value_q   <= s_axis_tdata[VAL_LSB +: DATA_W];
    end
    if (out_load) begin
      out_data_q   <= res_data;
      out_found_q  <= res_found;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_status_q, out_found_q};

  // Checks
  `SMET_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == ST_SCAN)
  `SMET_ASSERT_IMPL(a_drop_not_found, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])
  `SMET_ASSERT_IMPL(a_idle_scan_zero, state_q == ST_IDLE, scan_q == '0)
  `SMET_ASSERT_IMPL(a_write_only_at_load, wr.mem_en || wr.vld_en, out_load)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the sparse matrix entry table.
// Depends on smet_pkg and the sparse_matrix_entry_table top level; a local table
// model predicts every result item and a checker compares them as they leave.
`timescale 1ns / 1ps

module tb_top;
  import smet_pkg::*;

  // Command code with no operation behind it
  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam logic       ST_FULL     = 1'b1;
  localparam int         HOLD_CYCLES = 600;
  localparam int         ROWS_N      = 8;
  localparam int         COLS_N      = 10;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic              status;
  } cell_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [DATA_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  // Shadow copy of the entry table and the default register
  logic [KEY_W-1:0]   cell_row [ENTRIES];
  logic [KEY_W-1:0]   cell_col [ENTRIES];
  logic [DATA_W-1:0]  cell_data[ENTRIES];
  bit                 cell_used[ENTRIES];
  logic [DATA_W-1:0]  absent_value = '0;

  cell_result_t       pending_results[$];
  cell_result_t       oldest_result;
  int                 err_cnt      = 0;
  int                 snd_idle_pct = 13;
  int                 rcv_idle_pct = 78;
  bit                 hold_active  = 1'b0;
  logic [COORD_W-1:0] row_pool[ROWS_N];
  logic [COORD_W-1:0] col_pool[COLS_N];

  sparse_matrix_entry_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Lowest valid slot holding the key, or -1
  function automatic int lookup_cell(logic [KEY_W-1:0] r, logic [KEY_W-1:0] c);
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_used[i] && cell_row[i] == r && cell_col[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!cell_used[i]) return i;
    end
    return -1;
  endfunction

  // Run one command against the shadow table and return its result item
  function automatic cell_result_t apply_cell_command(logic [1:0] cmd, logic [COORD_W-1:0] row,
                                                      logic [COORD_W-1:0] col,
                                                      logic [DATA_W-1:0] val);
    cell_result_t     res;
    logic [KEY_W-1:0] r;
    logic [KEY_W-1:0] c;
    int               slot;
    int               fr;
    res  = '0;
    r    = row[KEY_W-1:0];
    c    = col[KEY_W-1:0];
    slot = lookup_cell(r, c);
    case (cmd)
      CMD_SET: begin
        if (slot >= 0) begin
          cell_data[slot] = val;
          res.found       = 1'b1;
        end else begin
          fr = lowest_free_slot();
          if (fr >= 0) begin
            cell_row[fr]  = r;
            cell_col[fr]  = c;
            cell_data[fr] = val;
            cell_used[fr] = 1'b1;
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      CMD_GET: begin
        if (slot >= 0) begin
          res.read_value = cell_data[slot];
          res.found      = 1'b1;
        end else begin
          res.read_value = absent_value;
        end
      end
      CMD_DEL: begin
        if (slot >= 0) begin
          cell_used[slot] = 1'b0;
          res.found       = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Check each result item against the oldest prediction, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h user=%b", m_axis_tdata,
                                  m_axis_tuser));
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata !== oldest_result.read_value)
          report_mismatch($sformatf("read_value %h, want %h", m_axis_tdata,
                                    oldest_result.read_value));
        if (m_axis_tuser[0] !== oldest_result.found)
          report_mismatch($sformatf("found %b, want %b", m_axis_tuser[0],
                                    oldest_result.found));
        if (m_axis_tuser[1] !== oldest_result.status)
          report_mismatch($sformatf("status %b, want %b", m_axis_tuser[1],
                                    oldest_result.status));
      end
    end
    m_axis_tready <= !hold_active && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Offer one command item, with a random gap first, and predict it once accepted
  task automatic send_command(input logic [1:0] cmd, input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col, input logic [DATA_W-1:0] val);
    bit lowered = 1'b0;
    while ($urandom_range(99) < snd_idle_pct) begin
      if (!lowered) begin
        s_axis_tvalid <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, col, row};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_cell_command(cmd, row, col, val));
  endtask

  // Stop offering items and wait for every predicted result
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write the default register; only called with no command in flight
  task automatic write_default(input logic [DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    absent_value = value;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_after_reset();
    send_command(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send_command(CMD_DEL, 16'h0000, 16'h0000, 32'h0000_0000);
    send_command(CMD_NOP, 16'h1234, 16'h4321, 32'hDEAD_BEEF);
    wait_results_done();
  endtask

  task automatic test_directed_ops();
    write_default(32'h7FFF_FFFF);
    send_command(CMD_GET, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_SET, 16'h0000, 16'h0000, 32'h8000_0000);
    send_command(CMD_SET, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_command(CMD_GET, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_GET, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    // overwrite an existing cell
    send_command(CMD_SET, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    // same row or same column alone must not match
    send_command(CMD_SET, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_GET, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_command(CMD_GET, 16'h0000, 16'hFFFF, 32'h1111_1111);
    send_command(CMD_DEL, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send_command(CMD_DEL, 16'h0000, 16'h0000, 32'h0000_0000);
    send_command(CMD_NOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // freed slot is reused by the next new key
    send_command(CMD_SET, 16'h5A5A, 16'hA5A5, 32'h0000_0001);
    send_command(CMD_GET, 16'h5A5A, 16'hA5A5, 32'h0000_0000);
    wait_results_done();
    write_default(32'h8000_0000);
    send_command(CMD_GET, 16'h0001, 16'h0002, 32'h0000_0000);
    send_command(CMD_DEL, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_DEL, 16'h0000, 16'hFFFF, 32'h0000_0000);
    wait_results_done();
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] live_row[$];
    logic [KEY_W-1:0] live_col[$];
    // fill the table and push a few sets past its capacity
    for (int i = 0; i < ENTRIES + 4; i++)
      send_command(CMD_SET, 16'h8000 | 16'(i), 16'(i * 3), $urandom);
    // a matching set still lands while the table is full
    send_command(CMD_SET, 16'h8000, 16'h0000, 32'h0BAD_F00D);
    send_command(CMD_GET, 16'h8000, 16'h0000, 32'h0000_0000);
    send_command(CMD_GET, 16'h8000 | 16'(ENTRIES + 3), 16'((ENTRIES + 3) * 3), 32'h0);
    send_command(CMD_DEL, 16'h8005, 16'd15, 32'h0000_0000);
    send_command(CMD_SET, 16'h7777, 16'h7777, 32'h7777_7777);
    send_command(CMD_GET, 16'h7777, 16'h7777, 32'h0000_0000);
    wait_results_done();
    // empty the table again
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_used[i]) begin
        live_row.push_back(cell_row[i]);
        live_col.push_back(cell_col[i]);
      end
    end
    foreach (live_row[j])
      send_command(CMD_DEL, COORD_W'(live_row[j]), COORD_W'(live_col[j]), $urandom);
    wait_results_done();
  endtask

  task automatic send_random_item();
    int                 pick;
    logic [1:0]         cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    pick = $urandom_range(99);
    row  = row_pool[$urandom_range(ROWS_N - 1)];
    col  = col_pool[$urandom_range(COLS_N - 1)];
    if (pick < 5) begin
      cmd = 2'($urandom_range(3));
      row = COORD_W'($urandom);
      col = COORD_W'($urandom);
    end else if (pick < 50) begin
      cmd = CMD_SET;
    end else if (pick < 85) begin
      cmd = CMD_GET;
    end else begin
      cmd = CMD_DEL;
    end
    send_command(cmd, row, col, $urandom);
  endtask

  task automatic test_backpressure();
    // stall the receiver long enough that the block refuses new items
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    join_none
    repeat (10) send_random_item();
    wait_results_done();
  endtask

  task automatic run_random_phase(input int n, input int snd_pct, input int rcv_pct,
                                  input logic [DATA_W-1:0] dflt);
    wait_results_done();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_default(dflt);
    repeat (n) send_random_item();
  endtask

  task automatic test_random_traffic();
    // key grid small enough that the table fills and entries get hit
    foreach (row_pool[i]) row_pool[i] = COORD_W'($urandom);
    foreach (col_pool[i]) col_pool[i] = COORD_W'($urandom);
    test_backpressure();
    run_random_phase(700, 13, 78, $urandom);
    run_random_phase(700, 78, 13, 32'h7FFF_FFFF);
    run_random_phase(600, 0, 0, 32'h8000_0000);
    wait_results_done();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_directed_ops();
    test_table_full();
    test_random_traffic();
    // drain, then allow for any stray result
    wait_results_done();
    repeat (ENTRIES + 16) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
